/* sv/scgc_pkg.sv */
// Shared types and constants for the serial CRC generate and check unit.
`timescale 1ns / 1ps
package scgc_pkg;

	// Widest generator supported; per-instance width follows from MAX_DEGREE.
	localparam int DEG_LIMIT    = 64;
	localparam int DEG_W        = 6;
	localparam int POLY_W       = 32;
	localparam int REM_OUT_W    = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int MAX_DEGREE_D = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLY_LOW   = 2'd0,
		CFG_DEGREE     = 2'd1,
		CFG_CHECK_MODE = 2'd2
	} cfg_idx_t;

	// Decoded configuration handed to the remainder update.
	typedef struct packed {
		logic [DEG_LIMIT-1:0] mask;
		logic [DEG_LIMIT-1:0] poly;
		logic                 check_mode;
	} crc_cfg_t;

endpackage

/* sv/scgc_cfg.sv */
// Configuration registers and decode of the effective generator polynomial.
`timescale 1ns / 1ps
module scgc_cfg import scgc_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output crc_cfg_t              cfg
);

	logic [POLY_W-1:0] poly_low_q;
	logic [DEG_W-1:0]  degree_q;
	logic              check_mode_q;
	logic [DEG_W:0]    eff_deg;
	logic [DEG_LIMIT-1:0] poly_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_low_q   <= '0;
			degree_q     <= DEG_W'(1);
			check_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_POLY_LOW:   poly_low_q   <= cfg_data[POLY_W-1:0];
				CFG_DEGREE:     degree_q     <= cfg_data[DEG_W-1:0];
				CFG_CHECK_MODE: check_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Degree zero acts as one; anything above the instance limit is clamped.
	always_comb begin
		eff_deg = {1'b0, degree_q};
		if (eff_deg == '0) begin
			eff_deg = (DEG_W+1)'(1);
		end
		if (eff_deg > (DEG_W+1)'(MAX_DEGREE)) begin
			eff_deg = (DEG_W+1)'(MAX_DEGREE);
		end
		poly_ext = {(DEG_LIMIT-POLY_W)'(0), poly_low_q};
		for (int i = 0; i < DEG_LIMIT; i++) begin
			cfg.mask[i] = ((DEG_W+1)'(i) < eff_deg);
			cfg.poly[i] = poly_ext[i] && ((DEG_W+1)'(i) < eff_deg);
		end
		cfg.check_mode = check_mode_q;
	end

endmodule

/* sv/scgc_step.sv */
// One-bit update of the running CRC remainder.
`timescale 1ns / 1ps
module scgc_step import scgc_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_D
) (
	input  crc_cfg_t              cfg,
	input  logic [MAX_DEGREE-1:0] rem_cur,
	input  logic                  data_bit,
	output logic [MAX_DEGREE-1:0] rem_next
);

	logic [MAX_DEGREE-1:0] mask;
	logic [MAX_DEGREE-1:0] poly;
	logic [MAX_DEGREE-1:0] rem_m;
	logic [MAX_DEGREE-1:0] shifted;
	logic                  top;
	logic                  feedback;

	always_comb begin
		mask  = cfg.mask[MAX_DEGREE-1:0];
		poly  = cfg.poly[MAX_DEGREE-1:0];
		rem_m = rem_cur & mask;
		// The mask is a run of ones from bit zero, so its highest set bit marks x^(degree-1).
		top   = |(rem_m & mask & ~(mask >> 1));
		// Check mode shifts the frame bit in at the bottom; generate mode
		// folds it into the feedback so the message is multiplied by x^degree.
		if (cfg.check_mode) begin
			shifted  = ((rem_m << 1) | MAX_DEGREE'(data_bit)) & mask;
			feedback = top;
		end else begin
			shifted  = (rem_m << 1) & mask;
			feedback = top ^ data_bit;
		end
		rem_next = feedback ? (shifted ^ poly) : shifted;
	end

endmodule

/* sv/serial_crc_generate_check_unit.sv */
// Top level of the bit-serial CRC generator and checker.
`timescale 1ns / 1ps
// Usage:
// Message or frame bits enter on the input channel (in_valid/in_ready), most
// significant first, one bit per word, with last_bit set on the final bit.
// Each accepted word lands in an input register; from there a single
// XOR layer updates the running remainder and, on a last word, loads the
// result register that drives the output channel (out_valid/out_ready).
// Only last words produce a result: remainder holds the check bits in
// generate mode, and error_flag is set in check mode when it is nonzero.
// out_valid rises when the last word moves from the input register into the
// result register, which happens only while the output is not stalled.
// Throughput is one bit per cycle while the output is not stalled.
// A stalled receiver holds the result register; the input register still
// takes one more word, and the chain stops only while both are full.
// Configuration writes (cfg_valid/cfg_ready, index and data) are taken at
// any time, but should only be issued while the unit is idle.
// Reset clears the running remainder, both handshakes, and sets poly_low to zero,
// degree to one and generate mode.
module serial_crc_generate_check_unit import scgc_pkg::*; #(
	parameter int MAX_DEGREE = MAX_DEGREE_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  msg_bit,
	input  logic                  last_bit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [REM_OUT_W-1:0]  remainder,
	output logic                  error_flag
);

	crc_cfg_t              cfg;
	logic                  valid_s1;
	logic                  bit_s1;
	logic                  last_s1;
	logic                  adv_s1;
	logic [MAX_DEGREE-1:0] rem_q;
	logic [MAX_DEGREE-1:0] rem_next;
	logic [2*DEG_LIMIT-1:0] rem_ext;
	logic                  out_valid_q;
	logic [REM_OUT_W-1:0]  remainder_q;
	logic                  error_flag_q;

	scgc_cfg #(.MAX_DEGREE(MAX_DEGREE)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	scgc_step #(.MAX_DEGREE(MAX_DEGREE)) u_step (
		.cfg      (cfg),
		.rem_cur  (rem_q),
		.data_bit (bit_s1),
		.rem_next (rem_next)
	);

	// The input word moves on unless a result is waiting in a stalled output.
	assign adv_s1   = !(out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign rem_ext  = {(2*DEG_LIMIT-MAX_DEGREE)'(0), rem_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bit_s1  <= msg_bit;
			last_s1 <= last_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s1 && adv_s1) begin
				rem_q <= last_s1 ? '0 : rem_next;
				if (last_s1) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1 && last_s1) begin
			remainder_q  <= rem_ext[REM_OUT_W-1:0];
			error_flag_q <= cfg.check_mode && (rem_next != '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign remainder  = remainder_q;
	assign error_flag = error_flag_q;

	a_rem_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1 && last_s1) |=> (rem_q == '0))
		else $error("running remainder not cleared after last word");

	a_stall_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a full pipeline");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(remainder_q) && $stable(error_flag_q)))
		else $error("waiting result overwritten");

	a_flag_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1 && last_s1 && !cfg.check_mode) |=> !error_flag_q)
		else $error("error flag raised in generate mode");

endmodule
